// File: src/axfp_pkg.sv
// ----------------------------------------------------------------------------
// axfp_pkg
// Shared types and constants for the ASCII frame parser.
// ----------------------------------------------------------------------------
`default_nettype none
package axfp_pkg;

   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_NUL   = 8'd0;
   localparam logic [7:0] CH_V     = 8'h56;
   localparam logic [7:0] CH_R     = 8'h52;
   localparam logic [7:0] CH_B     = 8'h42;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_E     = 8'h45;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   localparam logic [16:0] ANGLE_CAP = 17'd32768;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_SHORT = 3'd1;
   localparam logic [2:0] ST_START = 3'd2;
   localparam logic [2:0] ST_CSUM  = 3'd3;
   localparam logic [2:0] ST_OVER  = 3'd4;

   localparam logic [2:0] MK_H = 3'd0;
   localparam logic [2:0] MK_R = 3'd1;
   localparam logic [2:0] MK_B = 3'd2;
   localparam logic [2:0] MK_P = 3'd3;
   localparam logic [2:0] MK_A = 3'd4;
   localparam logic [2:0] MK_E = 3'd5;
   localparam logic [2:0] MK_X = 3'd6;

   // number phases
   localparam logic [2:0] PH_BLANK1 = 3'd0;
   localparam logic [2:0] PH_SIGN1  = 3'd1;
   localparam logic [2:0] PH_DIG1   = 3'd2;
   localparam logic [2:0] PH_BLANK2 = 3'd3;
   localparam logic [2:0] PH_SIGN2  = 3'd4;
   localparam logic [2:0] PH_DIG2   = 3'd5;
   localparam logic [2:0] PH_DONE   = 3'd6;
   localparam logic [2:0] PH_FAIL   = 3'd7;

   // classified byte passed from front to back
   typedef struct packed {
      logic       eol;      // LF: emit result and clear
      logic       take;     // byte enters the decoders
      logic       first;    // type character
      logic [3:0] bidx;     // board cell index, 9 means beyond
      logic [7:0] data;
      // line summary, meaningful with eol
      logic [2:0] status;
      logic       long13;
   } item_type;

   typedef struct packed {
      logic [2:0]  line_status;
      logic [2:0]  msg_kind;
      logic [7:0]  type_code;
      logic [15:0] angle_tenths;
      logic        board_valid;
      logic [17:0] board_cells;
      logic        alarm_valid;
      logic [7:0]  alarm_from;
      logic [7:0]  alarm_to;
   } result_type;

   function automatic logic is_blank(input logic [7:0] c);
      return c == 8'd32 || c == 8'd9 || c == 8'd11 || c == 8'd12;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
   endfunction

   function automatic logic [7:0] upper(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
   endfunction

   function automatic logic [2:0] kind_of(input logic [7:0] c);
      logic [2:0] k;
      unique case (c)
         CH_H:    k = MK_H;
         CH_R:    k = MK_R;
         CH_B:    k = MK_B;
         CH_P:    k = MK_P;
         CH_A:    k = MK_A;
         CH_E:    k = MK_E;
         default: k = MK_X;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

// File: src/axfp_if.sv
// ----------------------------------------------------------------------------
// axfp_if
// Valid/ready channel carrying a payload of configurable type.
// ----------------------------------------------------------------------------
`default_nettype none
interface axfp_if #(parameter type payload_type = logic [7:0]);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/ascii_xor_frame_parser.sv
// ----------------------------------------------------------------------------
// ascii_xor_frame_parser
// Parser for 'V'-framed text lines with a two-digit hex XOR checksum.
// ----------------------------------------------------------------------------
// Input channel req: one received byte per transfer. Result channel rsp: one
// result per LF byte, carrying line status, message kind and the decoded
// angle, board or alarm fields; other bytes give no result.
// Throughput: one byte per cycle while the queue has room, set by the framing
// front end, which updates count, hold and XOR for each accepted byte. A result
// reaches rsp through the queue: the LF item enters the two-entry queue on its
// transfer, and the decoder stage then loads its result register from it.
// Reset clears all line state; the first byte afterwards begins a new line.
// When the receiver stalls, the result register holds, the queue fills, and
// req_ready falls once the queue is full; no byte or result is lost.
// ----------------------------------------------------------------------------
`default_nettype none
module ascii_xor_frame_parser
   import axfp_pkg::*;
#(
   parameter int MAX_LINE = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   axfp_if.sink      req,
   axfp_if.source    rsp
);
   logic     f_valid, f_ready, q_valid, q_ready;
   item_type f_item, q_item;
   result_type res;

   axfp_front #(.MAX_LINE(MAX_LINE)) u_front (
      .clock, .reset,
      .in_valid (req.valid), .in_ready (req.ready), .in_byte (req.data),
      .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
   );

   axfp_fifo u_fifo (
      .clock, .reset,
      .in_valid (f_valid), .in_ready (f_ready), .in_item (f_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   axfp_back u_back (
      .clock, .reset,
      .in_valid (q_valid), .in_ready (q_ready), .in_item (q_item),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_res(res)
   );

   assign rsp.data = res;

endmodule
`default_nettype wire

// File: src/axfp_front.sv
// ----------------------------------------------------------------------------
// axfp_front
// Line framing: count, CR or NUL end, overflow, start char, two-byte hold,
// XOR and line status. Emits one classified item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none
module axfp_front
   import axfp_pkg::*;
#(
   parameter int MAX_LINE = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire logic [7:0] in_byte,
   output logic            out_valid,
   input  wire logic       out_ready,
   output item_type        out_item
);
   localparam int CW = $clog2(MAX_LINE + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          ended_ff, ended_in, over_ff, over_in;
   logic [7:0]    start_ff, start_in, hold0_ff, hold0_in, hold1_ff, hold1_in;
   logic [7:0]    xor_ff, xor_in;
   logic          fire;
   logic [2:0]    status;
   logic [CW-1:0] t_idx;

   assign in_ready  = out_ready;
   assign out_valid = in_valid;
   assign fire      = in_valid && out_ready;
   assign t_idx     = count_ff - CW'(3);

   always_comb begin
      if (over_ff)
         status = ST_OVER;
      else if (count_ff < CW'(3))
         status = ST_SHORT;
      else if (start_ff != CH_V)
         status = ST_START;
      else if (upper(hold0_ff) != hex_char(xor_ff[7:4]) ||
               upper(hold1_ff) != hex_char(xor_ff[3:0]))
         status = ST_CSUM;
      else
         status = ST_OK;
   end

   always_comb begin
      count_in = count_ff;
      ended_in = ended_ff;
      over_in  = over_ff;
      start_in = start_ff;
      hold0_in = hold0_ff;
      hold1_in = hold1_ff;
      xor_in   = xor_ff;
      out_item = '0;
      out_item.data   = hold0_ff;
      out_item.status = status;
      out_item.long13 = count_ff >= CW'(13);
      out_item.first  = count_ff == CW'(3);
      out_item.bidx   = (t_idx >= CW'(10)) ? 4'd9 : 4'(t_idx - CW'(1));
      if (in_byte == CH_LF) begin
         out_item.eol = 1'b1;
         count_in = '0;
         ended_in = 1'b0;
         over_in  = 1'b0;
         start_in = '0;
         hold0_in = '0;
         hold1_in = '0;
         xor_in   = '0;
      end else if (ended_ff || over_ff) begin
      end else if (in_byte == CH_CR || in_byte == CH_NUL) begin
         ended_in = 1'b1;
      end else if (count_ff >= CW'(MAX_LINE)) begin
         over_in = 1'b1;
      end else begin
         count_in = count_ff + CW'(1);
         if (count_ff == CW'(0))
            start_in = in_byte;
         else if (count_ff == CW'(1))
            hold0_in = in_byte;
         else if (count_ff == CW'(2))
            hold1_in = in_byte;
         else begin
            out_item.take = 1'b1;
            xor_in   = xor_ff ^ hold0_ff;
            hold0_in = hold1_ff;
            hold1_in = in_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ended_ff <= 1'b0;
         over_ff  <= 1'b0;
         start_ff <= '0;
         hold0_ff <= '0;
         hold1_ff <= '0;
         xor_ff   <= '0;
      end else if (fire) begin
         count_ff <= count_in;
         ended_ff <= ended_in;
         over_ff  <= over_in;
         start_ff <= start_in;
         hold0_ff <= hold0_in;
         hold1_ff <= hold1_in;
         xor_ff   <= xor_in;
      end
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_LINE)) else $error("line count beyond limit");
   a_lf_clears: assert property (@(posedge clock) disable iff (reset)
      fire && in_byte == CH_LF |=> count_ff == '0 && !over_ff && !ended_ff)
      else $error("line state not cleared at LF");
   a_over_sticky: assert property (@(posedge clock) disable iff (reset)
      over_ff && !(fire && in_byte == CH_LF) |=> over_ff)
      else $error("overflow flag dropped mid-line");

endmodule
`default_nettype wire

// File: src/axfp_fifo.sv
// ----------------------------------------------------------------------------
// axfp_fifo
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module axfp_fifo
   import axfp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire item_type  in_item,
   output logic           out_valid,
   input  wire logic      out_ready,
   output item_type       out_item
);
   item_type   mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_item  = mem_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wp_ff] <= in_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> wp_ff == rp_ff)
      else $error("queue pointers inconsistent");
   a_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 && !pop |=> cnt_ff == 2'd2)
      else $error("queue lost an entry");

endmodule
`default_nettype wire

// File: src/axfp_back.sv
// ----------------------------------------------------------------------------
// axfp_back
// Payload decoders (angle, board, alarm) and registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none
module axfp_back
   import axfp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire item_type in_item,
   output logic          out_valid,
   input  wire logic     out_ready,
   output result_type    out_res
);
   logic [7:0]  kind_ff, kind_in;
   logic [16:0] ang_ff, ang_in;
   logic [2:0]  ph_ff, ph_in;
   logic        neg_ff, neg_in;
   logic [17:0] cell_ff, cell_in;
   logic        cok_ff, cok_in;
   logic [7:0]  a1_ff, a1_in, a2_ff, a2_in;
   logic        vld_ff;
   result_type  res_ff, res_in;
   logic        fire, emit;
   logic [7:0]  c;
   logic [3:0]  dv;
   logic [20:0] ang_mul;

   assign in_ready  = !vld_ff || out_ready;
   assign fire      = in_valid && in_ready;
   assign emit      = fire && in_item.eol;
   assign out_valid = vld_ff;
   assign out_res   = res_ff;
   assign c         = in_item.data;
   assign dv        = 4'(c - CH_ZERO);
   assign ang_mul   = {ang_ff, 3'b0} + {2'b0, ang_ff, 1'b0} + {17'd0, dv};

   always_comb begin
      kind_in = kind_ff;
      ang_in  = ang_ff;
      ph_in   = ph_ff;
      neg_in  = neg_ff;
      cell_in = cell_ff;
      cok_in  = cok_ff;
      a1_in   = a1_ff;
      a2_in   = a2_ff;
      if (in_item.eol) begin
         kind_in = '0; ang_in = '0; ph_in = PH_BLANK1; neg_in = 1'b0;
         cell_in = '0; cok_in = 1'b1; a1_in = '0; a2_in = '0;
      end else if (in_item.take && in_item.first) begin
         kind_in = c;
      end else if (in_item.take) begin
         case (kind_ff)
            CH_R: begin
               if (ph_ff == PH_BLANK1) begin
                  if (is_blank(c)) begin
                  end else if (c == CH_PLUS) ph_in = PH_SIGN1;
                  else if (c == CH_MINUS) begin neg_in = 1'b1; ph_in = PH_SIGN1; end
                  else if (is_digit(c)) begin
                     ang_in = (ang_mul > 21'(ANGLE_CAP)) ? ANGLE_CAP : ang_mul[16:0];
                     ph_in  = PH_DIG1;
                  end else ph_in = PH_DONE;
               end else if (ph_ff == PH_SIGN1 || ph_ff == PH_DIG1) begin
                  if (is_digit(c)) begin
                     ang_in = (ang_mul > 21'(ANGLE_CAP)) ? ANGLE_CAP : ang_mul[16:0];
                     ph_in  = PH_DIG1;
                  end else ph_in = PH_DONE;
               end
            end
            CH_B: begin
               if (in_item.bidx < 4'd9) begin
                  if (c >= CH_ZERO && c <= 8'h32)
                     cell_in = cell_ff | (18'(c[1:0]) << {in_item.bidx, 1'b0});
                  else
                     cok_in = 1'b0;
               end
            end
            CH_A: begin
               case (ph_ff)
                  PH_BLANK1, PH_BLANK2, PH_SIGN1, PH_SIGN2: begin
                     if ((ph_ff == PH_BLANK1 || ph_ff == PH_BLANK2) && is_blank(c)) begin
                     end else if ((ph_ff == PH_BLANK1 || ph_ff == PH_BLANK2)
                                  && c == CH_PLUS)
                        ph_in = ph_ff + 3'd1;
                     else if ((ph_ff == PH_BLANK1 || ph_ff == PH_BLANK2)
                              && c == CH_MINUS) begin
                        neg_in = 1'b1;
                        ph_in  = ph_ff + 3'd1;
                     end else if (!is_digit(c))
                        ph_in = PH_FAIL;
                     else if (ph_ff < PH_BLANK2) begin
                        a1_in = {4'd0, dv}; ph_in = PH_DIG1;
                     end else begin
                        a2_in = {4'd0, dv}; ph_in = PH_DIG2;
                     end
                  end
                  PH_DIG1: begin
                     if (is_digit(c))
                        a1_in = 8'({a1_ff, 3'b0} + {a1_ff, 1'b0}) + {4'd0, dv};
                     else if (c == CH_COMMA) begin
                        if (neg_ff) a1_in = 8'd0 - a1_ff;
                        neg_in = 1'b0;
                        ph_in  = PH_BLANK2;
                     end else ph_in = PH_FAIL;
                  end
                  PH_DIG2: begin
                     if (is_digit(c))
                        a2_in = 8'({a2_ff, 3'b0} + {a2_ff, 1'b0}) + {4'd0, dv};
                     else begin
                        if (neg_ff) a2_in = 8'd0 - a2_ff;
                        neg_in = 1'b0;
                        ph_in  = PH_DONE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      res_in = '0;
      res_in.line_status = in_item.status;
      if (in_item.status == ST_OK) begin
         res_in.msg_kind  = kind_of(kind_ff);
         res_in.type_code = kind_ff;
         if (kind_ff == CH_R && (ph_ff == PH_DIG1 || ph_ff == PH_DONE))
            res_in.angle_tenths = neg_ff ? 16'(17'd0 - ang_ff)
               : ((ang_ff > 17'd32767) ? 16'd32767 : ang_ff[15:0]);
         if (kind_ff == CH_B && cok_ff && in_item.long13) begin
            res_in.board_valid = 1'b1;
            res_in.board_cells = cell_ff;
         end
         if (kind_ff == CH_A && (ph_ff == PH_DIG2 || ph_ff == PH_DONE)) begin
            res_in.alarm_valid = 1'b1;
            res_in.alarm_from  = a1_ff;
            res_in.alarm_to    = (ph_ff == PH_DIG2 && neg_ff) ? 8'd0 - a2_ff : a2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= '0; ang_ff <= '0; ph_ff <= PH_BLANK1; neg_ff <= 1'b0;
         cell_ff <= '0; cok_ff <= 1'b1; a1_ff <= '0; a2_ff <= '0;
         vld_ff  <= 1'b0;
      end else begin
         if (fire) begin
            kind_ff <= kind_in; ang_ff <= ang_in; ph_ff <= ph_in; neg_ff <= neg_in;
            cell_ff <= cell_in; cok_ff <= cok_in; a1_ff <= a1_in; a2_ff <= a2_in;
         end
         if (emit)
            vld_ff <= 1'b1;
         else if (out_ready)
            vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit)
         res_ff <= res_in;
   end

   a_ang_cap: assert property (@(posedge clock) disable iff (reset)
      ang_ff <= ANGLE_CAP) else $error("angle accumulator beyond cap");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff && !out_ready |=> vld_ff && $stable(res_ff))
      else $error("stalled result changed");
   a_eol_clr: assert property (@(posedge clock) disable iff (reset)
      emit |=> ph_ff == PH_BLANK1 && cok_ff && kind_ff == '0)
      else $error("decoder state not cleared after line");

endmodule
`default_nettype wire

// File: bench/ascii_xor_frame_parser_tb.sv
// ----------------------------------------------------------------------------
// ascii_xor_frame_parser_tb
// Self-checking bench: drives framed text lines byte by byte, predicts the
// line result at each LF and checks every result transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ascii_xor_frame_parser_tb
   import axfp_pkg::*;
();

   localparam int LINE_MAX  = 64;
   localparam int CYCLE_CAP = 2000000;

   localparam logic [2:0] FL_ENDED = 3'b001;
   localparam logic [2:0] FL_OVER  = 3'b010;
   localparam logic [2:0] FL_NEG   = 3'b100;

   logic clock = 1'b0;
   logic reset = 1'b1;

   axfp_if #(.payload_type(logic [7:0])) req_ch ();
   axfp_if #(.payload_type(result_type)) rsp_ch ();

   ascii_xor_frame_parser #(.MAX_LINE(LINE_MAX)) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // predictor state
   logic [7:0]  p_xor;
   logic [7:0]  p_hold0, p_hold1;
   int          p_count;
   logic [2:0]  p_flags;
   logic [7:0]  p_start, p_kind;
   logic [16:0] p_angle;
   logic [2:0]  p_phase;
   logic [17:0] p_cells;
   logic        p_cell_ok;
   logic [7:0]  p_al_first, p_al_second;

   result_type  line_results[$];
   int          errors = 0;
   int          lines_sent = 0;
   int          results_seen = 0;
   longint      cycles = 0;

   function automatic logic blank_ch(input logic [7:0] c);
      return c == 8'd32 || c == 8'd9 || c == 8'd11 || c == 8'd12;
   endfunction

   function automatic logic digit_ch(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      return n < 4'd10 ? 8'(CH_ZERO + n) : 8'("A" + n - 4'd10);
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction

   function automatic logic [2:0] kind_code(input logic [7:0] c);
      case (c)
         CH_H: return MK_H;
         CH_R: return MK_R;
         CH_B: return MK_B;
         CH_P: return MK_P;
         CH_A: return MK_A;
         CH_E: return MK_E;
         default: return MK_X;
      endcase
   endfunction

   task automatic clear_line();
      p_xor = '0; p_hold0 = '0; p_hold1 = '0; p_count = 0; p_flags = '0;
      p_start = '0; p_kind = '0; p_angle = '0; p_phase = PH_BLANK1;
      p_cells = '0; p_cell_ok = 1'b1; p_al_first = '0; p_al_second = '0;
   endtask

   task automatic angle_digit(input logic [7:0] c);
      logic [31:0] a;
      a = p_angle * 10 + (c - CH_ZERO);
      p_angle = (a > ANGLE_CAP) ? ANGLE_CAP : a[16:0];
   endtask

   task automatic decode_angle(input logic [7:0] c);
      case (p_phase)
         PH_BLANK1: begin
            if (blank_ch(c)) ;
            else if (c == CH_PLUS) p_phase = PH_SIGN1;
            else if (c == CH_MINUS) begin
               p_flags |= FL_NEG; p_phase = PH_SIGN1;
            end else if (digit_ch(c)) begin
               angle_digit(c); p_phase = PH_DIG1;
            end else p_phase = PH_DONE;
         end
         PH_SIGN1, PH_DIG1: begin
            if (digit_ch(c)) begin
               angle_digit(c); p_phase = PH_DIG1;
            end else p_phase = PH_DONE;
         end
         default: ;
      endcase
   endtask

   task automatic decode_alarm(input logic [7:0] c);
      logic handled;
      handled = 1'b0;
      if (p_phase == PH_BLANK1 || p_phase == PH_BLANK2) begin
         if (blank_ch(c)) handled = 1'b1;
         else if (c == CH_PLUS) begin
            p_phase++; handled = 1'b1;
         end else if (c == CH_MINUS) begin
            p_flags |= FL_NEG; p_phase++; handled = 1'b1;
         end
      end
      if (!handled) begin
         case (p_phase)
            PH_BLANK1, PH_BLANK2, PH_SIGN1, PH_SIGN2: begin
               if (!digit_ch(c)) p_phase = PH_FAIL;
               else if (p_phase < PH_BLANK2) begin
                  p_al_first = c - CH_ZERO; p_phase = PH_DIG1;
               end else begin
                  p_al_second = c - CH_ZERO; p_phase = PH_DIG2;
               end
            end
            PH_DIG1: begin
               if (digit_ch(c)) p_al_first = 8'(p_al_first * 10 + (c - CH_ZERO));
               else if (c == CH_COMMA) begin
                  if (p_flags & FL_NEG) p_al_first = -p_al_first;
                  p_flags &= ~FL_NEG;
                  p_phase = PH_BLANK2;
               end else p_phase = PH_FAIL;
            end
            PH_DIG2: begin
               if (digit_ch(c)) p_al_second = 8'(p_al_second * 10 + (c - CH_ZERO));
               else begin
                  if (p_flags & FL_NEG) p_al_second = -p_al_second;
                  p_flags &= ~FL_NEG;
                  p_phase = PH_DONE;
               end
            end
            default: ;
         endcase
      end
   endtask

   task automatic absorb_byte(input logic [7:0] c, input int t);
      p_xor ^= c;
      if (t == 0) p_kind = c;
      else case (p_kind)
         CH_R: decode_angle(c);
         CH_A: decode_alarm(c);
         CH_B: if (t - 1 < 9) begin
            if (c >= "0" && c <= "2") p_cells |= 18'(c - CH_ZERO) << (2 * (t - 1));
            else p_cell_ok = 1'b0;
         end
         default: ;
      endcase
   endtask

   // advances the line predictor by one byte; queues a result at LF
   task automatic predict_byte(input logic [7:0] c);
      result_type r;
      logic neg;
      if (c == CH_LF) begin
         r = '0;
         if (p_flags & FL_OVER) r.line_status = ST_OVER;
         else if (p_count < 3) r.line_status = ST_SHORT;
         else if (p_start != CH_V) r.line_status = ST_START;
         else if (to_upper(p_hold0) != hex_digit(p_xor[7:4]) ||
                  to_upper(p_hold1) != hex_digit(p_xor[3:0])) r.line_status = ST_CSUM;
         if (r.line_status == ST_OK) begin
            neg = (p_flags & FL_NEG) != 0;
            r.msg_kind = kind_code(p_kind);
            r.type_code = p_kind;
            if (r.msg_kind == MK_R && (p_phase == PH_DIG1 || p_phase == PH_DONE))
               r.angle_tenths = neg ? 16'(-p_angle) :
                                (p_angle > 17'd32767 ? 16'd32767 : p_angle[15:0]);
            if (r.msg_kind == MK_B && p_cell_ok && p_count >= 13) begin
               r.board_valid = 1'b1; r.board_cells = p_cells;
            end
            if (r.msg_kind == MK_A && (p_phase == PH_DIG2 || p_phase == PH_DONE)) begin
               r.alarm_valid = 1'b1; r.alarm_from = p_al_first;
               r.alarm_to = (p_phase == PH_DIG2 && neg) ? -p_al_second : p_al_second;
            end
         end
         line_results.push_back(r);
         clear_line();
      end else if (!(p_flags & (FL_ENDED | FL_OVER))) begin
         if (c == CH_CR || c == CH_NUL) p_flags |= FL_ENDED;
         else if (p_count >= LINE_MAX) p_flags |= FL_OVER;
         else begin
            if (p_count == 0) p_start = c;
            else if (p_count == 1) p_hold0 = c;
            else if (p_count == 2) p_hold1 = c;
            else begin
               absorb_byte(p_hold0, p_count - 3);
               p_hold0 = p_hold1; p_hold1 = c;
            end
            p_count++;
         end
      end
   endtask

   // valid stays high across back-to-back bytes; it drops only for an idle gap
   task automatic send_byte(input logic [7:0] c);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if ($urandom_range(0, 1)) gap = 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= c;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_byte(c);
      if (c == CH_LF) lines_sent++;
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_byte(s[i]);
   endtask

   // sends V, body, checksum (optionally corrupted, lower case), optional tail, LF
   task automatic send_frame(input string body, input logic bad, input logic lower,
                             input string tail);
      logic [7:0] x;
      string cs;
      x = '0;
      foreach (body[i]) x ^= body[i];
      if (bad) x ^= 8'(1 << $urandom_range(0, 7));
      cs = lower ? $sformatf("%02x", x) : $sformatf("%02X", x);
      send_text({"V", body, cs, tail});
      send_byte(CH_LF);
   endtask

   function automatic string rand_number(input int maxd);
      string s;
      int n;
      s = "";
      n = $urandom_range(1, maxd);
      repeat (n) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
      return s;
   endfunction

   function automatic string rand_pad();
      string s;
      logic [7:0] b[4] = '{8'd32, 8'd9, 8'd11, 8'd12};
      s = "";
      repeat ($urandom_range(0, 2)) s = {s, string'(b[$urandom_range(0, 3)])};
      return s;
   endfunction

   function automatic string rand_sign();
      case ($urandom_range(0, 2))
         0: return "+";
         1: return "-";
         default: return "";
      endcase
   endfunction

   function automatic string rand_junk(input int n);
      string s;
      logic [7:0] c;
      s = "";
      repeat (n) begin
         do c = 8'($urandom_range(0, 255));
         while (c == CH_LF || c == CH_CR || c == CH_NUL);
         s = {s, string'(c)};
      end
      return s;
   endfunction

   // result checker
   always @(posedge clock) begin
      result_type got, want;
      if (!reset) begin
         cycles++;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            results_seen++;
            if (line_results.size() == 0) begin
               $error("result transfer with nothing expected");
               errors++;
            end else begin
               want = line_results.pop_front();
               if (got.line_status !== want.line_status) begin
                  $error("line_status exp %0d got %0d", want.line_status, got.line_status);
                  errors++;
               end
               if (got.msg_kind !== want.msg_kind) begin
                  $error("msg_kind exp %0d got %0d", want.msg_kind, got.msg_kind); errors++;
               end
               if (got.type_code !== want.type_code) begin
                  $error("type_code exp %0h got %0h", want.type_code, got.type_code);
                  errors++;
               end
               if (got.angle_tenths !== want.angle_tenths) begin
                  $error("angle_tenths exp %0d got %0d", $signed(want.angle_tenths),
                         $signed(got.angle_tenths));
                  errors++;
               end
               if (got.board_valid !== want.board_valid) begin
                  $error("board_valid exp %0b got %0b", want.board_valid, got.board_valid);
                  errors++;
               end
               if (got.board_cells !== want.board_cells) begin
                  $error("board_cells exp %0h got %0h", want.board_cells, got.board_cells);
                  errors++;
               end
               if (got.alarm_valid !== want.alarm_valid) begin
                  $error("alarm_valid exp %0b got %0b", want.alarm_valid, got.alarm_valid);
                  errors++;
               end
               if (got.alarm_from !== want.alarm_from) begin
                  $error("alarm_from exp %0d got %0d", want.alarm_from, got.alarm_from);
                  errors++;
               end
               if (got.alarm_to !== want.alarm_to) begin
                  $error("alarm_to exp %0d got %0d", want.alarm_to, got.alarm_to);
                  errors++;
               end
            end
         end
         if (cycles > CYCLE_CAP) begin
            $display("ascii_xor_frame_parser_tb NOT OK");
            $finish;
         end
      end
   end

   // receiver stalls: a burst of ready, then a random hold-off
   initial begin
      int wait_n;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
         if (wait_n != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   task automatic test_directed();
      send_byte(CH_LF);                                 // empty line
      send_text("V0"); send_byte(CH_LF);                // too short
      send_frame("", 1'b0, 1'b0, "");                   // three chars, no type
      send_text("X0000"); send_byte(CH_LF);             // wrong start
      send_frame("H", 1'b0, 1'b0, "");
      send_frame("P12", 1'b0, 1'b1, "");
      send_frame("Eoops", 1'b0, 1'b0, "");
      send_frame("R1234", 1'b0, 1'b0, "");
      send_frame("R-99999", 1'b0, 1'b0, "");
      send_frame("R \t+99999x", 1'b0, 1'b1, "");
      send_frame("R-", 1'b0, 1'b0, "");
      send_frame("B012210021", 1'b0, 1'b0, "");
      send_frame("B01221002", 1'b0, 1'b0, "");
      send_frame("B0123", 1'b0, 1'b0, "");
      send_frame("A12,-7", 1'b0, 1'b0, "");
      send_frame("A -300, +1000x", 1'b0, 1'b0, "");
      send_frame("A5;6", 1'b0, 1'b0, "");
      send_frame("R7", 1'b1, 1'b0, "");                 // checksum mismatch
      send_frame("H", 1'b0, 1'b0, "\r\xff\x01");        // tail after CR
      send_text("VH48"); send_byte(CH_NUL); send_text("junk"); send_byte(CH_LF);
      send_text({"V", rand_junk(LINE_MAX + 3)}); send_byte(CH_LF);   // overflow
      send_byte(8'hFF); send_byte(CH_LF);
   endtask

   task automatic test_random_frames();
      string body;
      int sel;
      string kinds;
      kinds = "ABEHPR";
      repeat (26) begin
         sel = $urandom_range(0, 9);
         case (sel)
            0, 1: body = {"R", rand_pad(), rand_sign(), rand_number(7),
                          rand_junk($urandom_range(0, 2))};
            2, 3: begin
               body = "B";
               repeat ($urandom_range(8, 11))
                  body = {body, string'(8'("0" + $urandom_range(0, 2)))};
               if ($urandom_range(0, 3) == 0) body[$urandom_range(1, 9)] = "7";
            end
            4, 5: body = {"A", rand_pad(), rand_sign(), rand_number(4), ",", rand_pad(),
                          rand_sign(), rand_number(4), rand_junk($urandom_range(0, 1))};
            6: body = {string'(kinds[$urandom_range(0, 5)]),
                       rand_junk($urandom_range(0, 8))};
            7: body = rand_junk($urandom_range(0, 12));
            8: body = {"R", rand_junk($urandom_range(1, 60))};
            default: body = {"A", rand_number(3), rand_junk($urandom_range(0, 3))};
         endcase
         if (body.len() > LINE_MAX - 3 && $urandom_range(0, 1)) body = body.substr(0, 20);
         send_frame(body, $urandom_range(0, 7) == 0, $urandom_range(0, 1),
                    $urandom_range(0, 9) == 0 ? {"\r", rand_junk(3)} : "");
      end
   endtask

   task automatic test_random_noise();
      logic [7:0] c;
      repeat (60) begin
         c = 8'($urandom_range(0, 255));
         send_byte(c);
         if ($urandom_range(0, 5) == 0) send_byte(CH_LF);
      end
      send_byte(CH_LF);
   endtask

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      clear_line();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_frames();
      test_random_noise();
      test_random_frames();
      req_ch.valid <= 1'b0;
      while (line_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d lines (%0d results): short, bad start, checksum, overflow,",
               lines_sent, results_seen);
      $display("angle, board and alarm frames with random pacing and receiver stalls");
      if (errors == 0) begin
         $display("ascii_xor_frame_parser_tb OK");
      end else begin
         $display("ascii_xor_frame_parser_tb NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire
